// File: sv/laplacian_stencil_row_gen_core_defines.svh
// Assertion macros used by the stencil row generator's row emitter.
`ifndef LAPLACIAN_STENCIL_ROW_GEN_CORE_DEFINES_SVH
`define LAPLACIAN_STENCIL_ROW_GEN_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked only out of reset.
`define LSRG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define LSRG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LSRG_ASSERT(lbl, prop, msg)
`define LSRG_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: sv/lsrg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsrg_pkg;

    localparam int MAX_EXTENT_DEF = 1024;

    localparam int EXT_W   = 11;
    localparam int POS_W   = 10;
    localparam int COEF_W  = 24;
    localparam int VAL_W   = 28;
    localparam int COL_W   = 30;
    localparam int DIR_W   = 3;
    localparam int IDX_W   = 3;
    localparam int NDIR    = 7;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_EXTENT_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_EXTENT_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_EXTENT_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_X   = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEF_Y   = 3'd4;
    localparam logic [IDX_W-1:0] REG_COEF_Z   = 3'd5;

    localparam logic [EXT_W-1:0]  EXTENT_RST = 11'd32;
    localparam logic [COEF_W-1:0] COEF_RST   = 24'd65536;

    typedef enum logic [DIR_W-1:0] {
        DIR_CENTER = 3'd0,
        DIR_WEST   = 3'd1,
        DIR_EAST   = 3'd2,
        DIR_SOUTH  = 3'd3,
        DIR_NORTH  = 3'd4,
        DIR_FRONT  = 3'd5,
        DIR_BACK   = 3'd6
    } lsrg_dir_t;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
    } lsrg_point_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] coefficient;
        logic [COL_W-1:0]        column_index;
        logic [DIR_W-1:0]        direction;
        logic                    bad_coord;
        logic                    last_entry;
    } lsrg_entry_t;

    // Effective (saturated) grid setup
    typedef struct packed {
        logic [EXT_W-1:0]  nx;
        logic [EXT_W-1:0]  ny;
        logic [EXT_W-1:0]  nz;
        logic [COEF_W-1:0] cx;
        logic [COEF_W-1:0] cy;
        logic [COEF_W-1:0] cz;
    } lsrg_cfg_t;

    // One finished row, handed from the index pipe to the emitter
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [EXT_W-1:0] nx;
        logic [COL_W-1:0] plane;
        logic [VAL_W-1:0] center;
        logic [NDIR-1:0]  pend;
        logic             bad;
    } lsrg_row_t;

endpackage

`default_nettype wire

// File: sv/laplacian_stencil_row_gen_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Seven-point Laplacian row generator. A grid point is taken on start while busy is low;
// its row leaves as one word per cycle on strobe/entry, in the order center, west, east,
// south, north, front, back, with neighbors outside the box left out, and last_entry on the
// final word. A point outside the configured extents gives one word with bad_coord set. The
// first word of a row leaves the output register after its point has passed the capture
// register, both product stages, the row register and the emitter's active register, and its
// words follow back to back. A row has 7 words inside the box, fewer on its boundary (down to
// 1 where every extent is 1), 1 when flagged; the single output word port paces the points, and
// the index pipe behind it holds up to four more points. The receiver cannot stall: every strobe
// carries a word that must be taken. Write the configuration only while nothing is in flight.

module laplacian_stencil_row_gen_core #(
    parameter int MAX_EXTENT = lsrg_pkg::MAX_EXTENT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  lsrg_pkg::lsrg_point_t              point,
    input  wire logic                          cfg_we,
    input  wire logic [lsrg_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [lsrg_pkg::COEF_W-1:0]   cfg_data,
    output logic                               strobe,
    output lsrg_pkg::lsrg_entry_t              entry
);

    lsrg_pkg::lsrg_cfg_t cfg;
    lsrg_pkg::lsrg_row_t row;
    logic                row_valid;
    logic                row_ready;

    lsrg_cfg_regs #(
        .MAX_EXTENT (MAX_EXTENT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsrg_index_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point     (point),
        .cfg       (cfg),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row       (row)
    );

    lsrg_row_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row       (row),
        .cfg       (cfg),
        .strobe    (strobe),
        .entry     (entry)
    );

endmodule

`default_nettype wire

// File: sv/lsrg_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module lsrg_cfg_regs #(
    parameter int MAX_EXTENT = lsrg_pkg::MAX_EXTENT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [lsrg_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [lsrg_pkg::COEF_W-1:0]   cfg_data,
    output lsrg_pkg::lsrg_cfg_t                cfg
);

    logic [lsrg_pkg::EXT_W-1:0]  ext_x_reg, ext_y_reg, ext_z_reg;
    logic [lsrg_pkg::COEF_W-1:0] coef_x_reg, coef_y_reg, coef_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_x_reg  <= lsrg_pkg::EXTENT_RST;
            ext_y_reg  <= lsrg_pkg::EXTENT_RST;
            ext_z_reg  <= lsrg_pkg::EXTENT_RST;
            coef_x_reg <= lsrg_pkg::COEF_RST;
            coef_y_reg <= lsrg_pkg::COEF_RST;
            coef_z_reg <= lsrg_pkg::COEF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lsrg_pkg::REG_EXTENT_X: ext_x_reg  <= cfg_data[lsrg_pkg::EXT_W-1:0];
                lsrg_pkg::REG_EXTENT_Y: ext_y_reg  <= cfg_data[lsrg_pkg::EXT_W-1:0];
                lsrg_pkg::REG_EXTENT_Z: ext_z_reg  <= cfg_data[lsrg_pkg::EXT_W-1:0];
                lsrg_pkg::REG_COEF_X:   coef_x_reg <= cfg_data;
                lsrg_pkg::REG_COEF_Y:   coef_y_reg <= cfg_data;
                lsrg_pkg::REG_COEF_Z:   coef_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [lsrg_pkg::EXT_W-1:0] sat_ext(
        input logic [lsrg_pkg::EXT_W-1:0] e
    );
        // clamp to the largest supported extent
        if (32'(e) > 32'(MAX_EXTENT))
            return lsrg_pkg::EXT_W'(MAX_EXTENT);
        return e;
    endfunction

    always_comb
    begin
        cfg.nx = sat_ext(ext_x_reg);
        cfg.ny = sat_ext(ext_y_reg);
        cfg.nz = sat_ext(ext_z_reg);
        cfg.cx = coef_x_reg;
        cfg.cy = coef_y_reg;
        cfg.cz = coef_z_reg;
    end

endmodule

`default_nettype wire

// File: sv/lsrg_index_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module lsrg_index_pipe (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  lsrg_pkg::lsrg_point_t      point,
    input  lsrg_pkg::lsrg_cfg_t        cfg,
    output logic                       row_valid,
    input  wire logic                  row_ready,
    output lsrg_pkg::lsrg_row_t        row
);

    localparam int PA_W = lsrg_pkg::EXT_W + lsrg_pkg::POS_W;    // nx*y
    localparam int PL_W = 2 * lsrg_pkg::EXT_W;                  // nx*ny
    localparam int PZ_W = PL_W + lsrg_pkg::POS_W;               // plane*z
    localparam int BS_W = PA_W + 1;                             // x + nx*y
    localparam int CS_W = lsrg_pkg::COEF_W + 2;                 // cx+cy+cz

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic adv1, adv2, adv3;

    // stage 1: captured point
    lsrg_pkg::lsrg_point_t s1_pt_reg;

    // stage 2: first products and range check
    lsrg_pkg::lsrg_point_t s2_pt_reg;
    logic                  s2_bad_reg;
    logic [PA_W-1:0]       s2_prod_reg;
    logic [PL_W-1:0]       s2_plane_reg;

    // stage 3: plane product and partial index
    lsrg_pkg::lsrg_point_t s3_pt_reg;
    logic                  s3_bad_reg;
    logic [BS_W-1:0]       s3_base_reg;
    logic [PZ_W-1:0]       s3_pz_reg;
    logic [PL_W-1:0]       s3_plane_reg;

    lsrg_pkg::lsrg_row_t   row_reg;
    logic                  row_valid_reg;

    logic                  bad_a;
    logic [PA_W-1:0]       prod_a;
    logic [PL_W-1:0]       plane_a;
    lsrg_pkg::lsrg_row_t   row_next;
    logic [CS_W-1:0]       csum;

    assign adv3 = !row_valid_reg || row_ready;
    assign adv2 = !s3_valid_reg || adv3;
    assign adv1 = !s2_valid_reg || adv2;
    assign busy = s1_valid_reg && !adv1;

    // stage A logic
    always_comb
    begin
        bad_a = ({1'b0, s1_pt_reg.pos_x} >= cfg.nx) ||
                ({1'b0, s1_pt_reg.pos_y} >= cfg.ny) ||
                ({1'b0, s1_pt_reg.pos_z} >= cfg.nz);
        prod_a  = cfg.nx * s1_pt_reg.pos_y;
        plane_a = cfg.nx * cfg.ny;
    end

    // stage C logic: final index, neighbor set, center value
    always_comb
    begin
        csum = CS_W'(cfg.cx) + CS_W'(cfg.cy) + CS_W'(cfg.cz);
        row_next.col    = s3_pz_reg[lsrg_pkg::COL_W-1:0]
                        + lsrg_pkg::COL_W'(s3_base_reg);
        row_next.nx     = cfg.nx;
        row_next.plane  = lsrg_pkg::COL_W'(s3_plane_reg);
        row_next.center = lsrg_pkg::VAL_W'(0) - lsrg_pkg::VAL_W'({csum, 1'b0});
        row_next.bad    = s3_bad_reg;
        if (s3_bad_reg)
        begin
            row_next.pend = lsrg_pkg::NDIR'(1);
        end
        else
        begin
            row_next.pend[lsrg_pkg::DIR_CENTER] = 1'b1;
            row_next.pend[lsrg_pkg::DIR_WEST]   = s3_pt_reg.pos_x != '0;
            row_next.pend[lsrg_pkg::DIR_EAST]   = ({1'b0, s3_pt_reg.pos_x} + 1'b1) < cfg.nx;
            row_next.pend[lsrg_pkg::DIR_SOUTH]  = s3_pt_reg.pos_y != '0;
            row_next.pend[lsrg_pkg::DIR_NORTH]  = ({1'b0, s3_pt_reg.pos_y} + 1'b1) < cfg.ny;
            row_next.pend[lsrg_pkg::DIR_FRONT]  = s3_pt_reg.pos_z != '0;
            row_next.pend[lsrg_pkg::DIR_BACK]   = ({1'b0, s3_pt_reg.pos_z} + 1'b1) < cfg.nz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            row_valid_reg <= 1'b0;
        end
        else
        begin
            if (!busy)
                s1_valid_reg <= start;
            if (adv1)
                s2_valid_reg <= s1_valid_reg;
            if (adv2)
                s3_valid_reg <= s2_valid_reg;
            if (adv3)
                row_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy && start)
            s1_pt_reg <= point;
        if (adv1)
        begin
            s2_pt_reg    <= s1_pt_reg;
            s2_bad_reg   <= bad_a;
            s2_prod_reg  <= prod_a;
            s2_plane_reg <= plane_a;
        end
        if (adv2)
        begin
            s3_pt_reg    <= s2_pt_reg;
            s3_bad_reg   <= s2_bad_reg;
            s3_base_reg  <= BS_W'(s2_pt_reg.pos_x) + BS_W'(s2_prod_reg);
            s3_pz_reg    <= s2_plane_reg * s2_pt_reg.pos_z;
            s3_plane_reg <= s2_plane_reg;
        end
        if (adv3)
            row_reg <= row_next;
    end

    assign row_valid = row_valid_reg;
    assign row       = row_reg;

endmodule

`default_nettype wire

// File: sv/lsrg_row_emit.sv
`timescale 1ns / 1ps
`default_nettype none

`include "laplacian_stencil_row_gen_core_defines.svh"

module lsrg_row_emit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  row_valid,
    output logic                       row_ready,
    input  lsrg_pkg::lsrg_row_t        row,
    input  lsrg_pkg::lsrg_cfg_t        cfg,
    output logic                       strobe,
    output lsrg_pkg::lsrg_entry_t      entry
);

    logic                          act_valid_reg;
    lsrg_pkg::lsrg_row_t           act_reg;
    logic                          strobe_reg;
    lsrg_pkg::lsrg_entry_t         entry_reg;

    logic [lsrg_pkg::NDIR-1:0]     pick;
    logic [lsrg_pkg::NDIR-1:0]     rest;
    logic                          last;
    lsrg_pkg::lsrg_dir_t           dir;
    lsrg_pkg::lsrg_entry_t         entry_next;

    function automatic lsrg_pkg::lsrg_dir_t first_dir(
        input logic [lsrg_pkg::NDIR-1:0] p
    );
        lsrg_pkg::lsrg_dir_t d;
        d = lsrg_pkg::DIR_CENTER;
        for (int i = lsrg_pkg::NDIR - 1; i >= 0; i--)
        begin
            if (p[i])
                d = lsrg_pkg::lsrg_dir_t'(lsrg_pkg::DIR_W'(i));
        end
        return d;
    endfunction

    always_comb
    begin
        pick = act_reg.pend & (~act_reg.pend + 1'b1);
        rest = act_reg.pend & ~pick;
        last = (rest == '0);
        dir  = first_dir(act_reg.pend);
    end

    assign row_ready = !act_valid_reg || last;

    always_comb
    begin
        entry_next.direction  = dir;
        entry_next.bad_coord  = act_reg.bad;
        entry_next.last_entry = last;
        case (dir)
            lsrg_pkg::DIR_CENTER:
            begin
                entry_next.coefficient  = act_reg.center;
                entry_next.column_index = act_reg.col;
            end
            lsrg_pkg::DIR_WEST:
            begin
                entry_next.coefficient  = lsrg_pkg::VAL_W'(cfg.cx);
                entry_next.column_index = act_reg.col - 1'b1;
            end
            lsrg_pkg::DIR_EAST:
            begin
                entry_next.coefficient  = lsrg_pkg::VAL_W'(cfg.cx);
                entry_next.column_index = act_reg.col + 1'b1;
            end
            lsrg_pkg::DIR_SOUTH:
            begin
                entry_next.coefficient  = lsrg_pkg::VAL_W'(cfg.cy);
                entry_next.column_index = act_reg.col - lsrg_pkg::COL_W'(act_reg.nx);
            end
            lsrg_pkg::DIR_NORTH:
            begin
                entry_next.coefficient  = lsrg_pkg::VAL_W'(cfg.cy);
                entry_next.column_index = act_reg.col + lsrg_pkg::COL_W'(act_reg.nx);
            end
            lsrg_pkg::DIR_FRONT:
            begin
                entry_next.coefficient  = lsrg_pkg::VAL_W'(cfg.cz);
                entry_next.column_index = act_reg.col - act_reg.plane;
            end
            lsrg_pkg::DIR_BACK:
            begin
                entry_next.coefficient  = lsrg_pkg::VAL_W'(cfg.cz);
                entry_next.column_index = act_reg.col + act_reg.plane;
            end
            default:
            begin
                entry_next.coefficient  = '0;
                entry_next.column_index = '0;
            end
        endcase
        // an out-of-range point yields a single flagged word with zero payload
        if (act_reg.bad)
        begin
            entry_next.coefficient  = '0;
            entry_next.column_index = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= act_valid_reg;
            if (row_ready)
                act_valid_reg <= row_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act_valid_reg)
            entry_reg <= entry_next;
        // load the next row or drop the word just sent
        if (row_ready)
            act_reg <= row;
        else
            act_reg.pend <= rest;
    end

    assign strobe = strobe_reg;
    assign entry  = entry_reg;

    `LSRG_ASSERT(a_pend_nonempty, act_valid_reg |-> (act_reg.pend != '0), "active row has no word")
    `LSRG_ASSERT(a_bad_single, (strobe_reg && entry_reg.bad_coord) |-> entry_reg.last_entry, "flagged word is not last")
    `LSRG_ASSERT(a_row_contig, (strobe_reg && !entry_reg.last_entry) |=> strobe_reg, "row words not back to back")
    `LSRG_ASSERT(a_dir_order, (strobe_reg && !entry_reg.last_entry) |=> (entry_reg.direction > $past(entry_reg.direction)), "row words out of order")
    `LSRG_ASSERT_ALWAYS(a_no_strobe_rst, !rst_n |-> (strobe_reg !== 1'b1), "strobe during reset")

endmodule

`default_nettype wire

// File: dv/lsrg_row_checker.sv
`timescale 1ns / 1ps

// Watches the point and row channels of the stencil row generator, predicts every row
// word from its own copy of the grid setup, and compares the words in order.
module lsrg_row_checker
    import lsrg_pkg::*;
#(
    parameter int MAX_EXTENT = MAX_EXTENT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  lsrg_point_t         point,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [COEF_W-1:0]   cfg_data,
    input  logic                strobe,
    input  lsrg_entry_t         entry,
    output int                  errors,
    output int                  outstanding
);

    logic [EXT_W-1:0]  grid_nx, grid_ny, grid_nz;
    logic [COEF_W-1:0] inv_hx2, inv_hy2, inv_hz2;
    lsrg_entry_t       row_words [$];
    int                fail_count;

    function automatic logic [63:0] clip_extent(input logic [EXT_W-1:0] e);
        return (e > MAX_EXTENT) ? 64'(MAX_EXTENT) : 64'(e);
    endfunction

    function automatic lsrg_entry_t make_word(input logic [63:0] coef, input logic [63:0] col,
                                              input lsrg_dir_t dir);
        lsrg_entry_t w;
        w.coefficient  = coef[VAL_W-1:0];
        w.column_index = col[COL_W-1:0];
        w.direction    = dir;
        w.bad_coord    = 1'b0;
        w.last_entry   = 1'b0;
        return w;
    endfunction

    // Append a predicted word at the tail of the expected queue.
    task automatic queue_word(input lsrg_entry_t w);
        row_words.insert(row_words.size(), w);
    endtask

    task automatic predict_row(input lsrg_point_t p);
        logic [63:0] x, y, z, nx, ny, nz, plane, c, center;
        lsrg_entry_t words [7];
        lsrg_entry_t w;
        int          n;
        x  = 64'(p.pos_x);
        y  = 64'(p.pos_y);
        z  = 64'(p.pos_z);
        nx = clip_extent(grid_nx);
        ny = clip_extent(grid_ny);
        nz = clip_extent(grid_nz);
        n  = 0;
        if (x >= nx || y >= ny || z >= nz) begin
            w = make_word(64'd0, 64'd0, DIR_CENTER);
            w.bad_coord  = 1'b1;
            w.last_entry = 1'b1;
            queue_word(w);
        end else begin
            plane  = nx * ny;
            c      = x + nx * y + plane * z;
            center = 64'd0 - 64'd2 * (64'(inv_hx2) + 64'(inv_hy2) + 64'(inv_hz2));
            words[n] = make_word(center, c, DIR_CENTER);
            n++;
            if (x > 0) begin
                words[n] = make_word(64'(inv_hx2), c - 64'd1, DIR_WEST);
                n++;
            end
            if (x + 1 < nx) begin
                words[n] = make_word(64'(inv_hx2), c + 64'd1, DIR_EAST);
                n++;
            end
            if (y > 0) begin
                words[n] = make_word(64'(inv_hy2), c - nx, DIR_SOUTH);
                n++;
            end
            if (y + 1 < ny) begin
                words[n] = make_word(64'(inv_hy2), c + nx, DIR_NORTH);
                n++;
            end
            if (z > 0) begin
                words[n] = make_word(64'(inv_hz2), c - plane, DIR_FRONT);
                n++;
            end
            if (z + 1 < nz) begin
                words[n] = make_word(64'(inv_hz2), c + plane, DIR_BACK);
                n++;
            end
            words[n-1].last_entry = 1'b1;
            for (int i = 0; i < n; i++)
                queue_word(words[i]);
        end
    endtask

    task automatic check_word(input lsrg_entry_t got);
        lsrg_entry_t want;
        if (row_words.size() == 0) begin
            if (fail_count < 10)
                $display("%0t: unexpected row word: coef %0d col %0d dir %0d bad %0b last %0b",
                         $realtime, $signed(got.coefficient), got.column_index,
                         got.direction, got.bad_coord, got.last_entry);
            fail_count++;
            return;
        end
        want = row_words.pop_front();
        if (got.coefficient !== want.coefficient || got.column_index !== want.column_index ||
            got.direction !== want.direction || got.bad_coord !== want.bad_coord ||
            got.last_entry !== want.last_entry) begin
            if (fail_count < 10) begin
                $display("%0t: row word mismatch", $realtime);
                $display("  expected coef %0d col %0d dir %0d bad %0b last %0b",
                         $signed(want.coefficient), want.column_index, want.direction,
                         want.bad_coord, want.last_entry);
                $display("  actual   coef %0d col %0d dir %0d bad %0b last %0b",
                         $signed(got.coefficient), got.column_index, got.direction,
                         got.bad_coord, got.last_entry);
            end
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            grid_nx     <= EXTENT_RST;
            grid_ny     <= EXTENT_RST;
            grid_nz     <= EXTENT_RST;
            inv_hx2     <= COEF_RST;
            inv_hy2     <= COEF_RST;
            inv_hz2     <= COEF_RST;
            row_words.delete();
            fail_count  = 0;
            errors      <= 0;
            outstanding <= 0;
        end else begin
            if (cfg_we === 1'b1) begin
                case (cfg_index)
                    REG_EXTENT_X: grid_nx <= cfg_data[EXT_W-1:0];
                    REG_EXTENT_Y: grid_ny <= cfg_data[EXT_W-1:0];
                    REG_EXTENT_Z: grid_nz <= cfg_data[EXT_W-1:0];
                    REG_COEF_X:   inv_hx2 <= cfg_data;
                    REG_COEF_Y:   inv_hy2 <= cfg_data;
                    REG_COEF_Z:   inv_hz2 <= cfg_data;
                    default: ;
                endcase
            end
            // queue the new row first: its first word never leaves on the edge it is taken
            if (start === 1'b1 && busy === 1'b0)
                predict_row(point);
            if (strobe === 1'b1)
                check_word(entry);
            else if (strobe !== 1'b0) begin
                if (fail_count < 10)
                    $display("%0t: strobe is unknown", $realtime);
                fail_count++;
            end
            errors      <= fail_count;
            outstanding <= row_words.size();
        end
    end

endmodule

// File: dv/laplacian_stencil_row_gen_core_test.sv
`timescale 1ns / 1ps

module laplacian_stencil_row_gen_core_test;

    import lsrg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    lsrg_point_t        point;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [COEF_W-1:0]  cfg_data;
    logic               strobe;
    lsrg_entry_t        entry;
    int                 errors;
    int                 outstanding;
    int                 cycle_count;
    int                 box_n [3];
    bit                 allow_gaps;

    laplacian_stencil_row_gen_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point     (point),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .entry     (entry)
    );

    lsrg_row_checker row_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .point       (point),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .strobe      (strobe),
        .entry       (entry),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Extent words carry junk above bit 10; the block keeps only the low bits.
    task automatic set_grid(input logic [EXT_W-1:0] nx, input logic [EXT_W-1:0] ny,
                            input logic [EXT_W-1:0] nz, input logic [COEF_W-1:0] cx,
                            input logic [COEF_W-1:0] cy, input logic [COEF_W-1:0] cz);
        write_reg(REG_EXTENT_X, {13'($urandom), nx});
        write_reg(REG_EXTENT_Y, {13'($urandom), ny});
        write_reg(REG_EXTENT_Z, {13'($urandom), nz});
        write_reg(REG_COEF_X, cx);
        write_reg(REG_COEF_Y, cy);
        write_reg(REG_COEF_Z, cz);
        box_n[0] = (nx > MAX_EXTENT_DEF) ? MAX_EXTENT_DEF : nx;
        box_n[1] = (ny > MAX_EXTENT_DEF) ? MAX_EXTENT_DEF : ny;
        box_n[2] = (nz > MAX_EXTENT_DEF) ? MAX_EXTENT_DEF : nz;
    endtask

    task automatic send_point(input int x, input int y, input int z);
        @(negedge clk);
        start <= 1'b1;
        point <= '{pos_x: POS_W'(x), pos_y: POS_W'(y), pos_z: POS_W'(z)};
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // Lower start and scramble the point while idle.
    task automatic hold_off(input int cycles);
        for (int i = 0; i < cycles; i++) begin
            @(negedge clk);
            start <= 1'b0;
            point <= lsrg_point_t'($urandom);
        end
    endtask

    // Hold off until every predicted word of the phase has left the block.
    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic int pick_coord(input int n);
        int r;
        r = $urandom_range(0, 19);
        if (n == 0 || r < 2)
            return $urandom_range(0, 1023);
        if (r < 6)
            return r[0] ? 0 : n - 1;
        return $urandom_range(0, n - 1);
    endfunction

    function automatic logic [EXT_W-1:0] pick_extent;
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r < 13)
            return EXT_W'($urandom_range(1, 12));
        if (r < 17)
            return EXT_W'($urandom_range(1, 1024));
        return EXT_W'($urandom_range(1024, 2047));
    endfunction

    task automatic random_points(input int count);
        for (int i = 0; i < count; i++) begin
            if (allow_gaps && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 18));
            send_point(pick_coord(box_n[0]), pick_coord(box_n[1]), pick_coord(box_n[2]));
        end
    endtask

    initial begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        point      = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_EXTENT_X;
        cfg_data   = '0;
        allow_gaps = 1'b1;
        box_n[0]   = EXTENT_RST;
        box_n[1]   = EXTENT_RST;
        box_n[2]   = EXTENT_RST;
        cycle_count = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // reset setup: corners, interior, faces and each axis just out of the box
        send_point(0, 0, 0);
        send_point(31, 31, 31);
        send_point(5, 6, 7);
        send_point(0, 17, 31);
        hold_off(3);
        send_point(31, 0, 9);
        send_point(32, 0, 0);
        send_point(0, 32, 0);
        send_point(0, 0, 32);
        send_point(1023, 1023, 1023);
        drain();

        // saturated x extent and the largest coefficients give the most negative center
        set_grid(11'd2047, 11'd1024, 11'd1024, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_point(0, 0, 0);
        send_point(1023, 1023, 1023);
        send_point(512, 0, 1023);
        send_point(1023, 511, 0);
        random_points(40);
        drain();

        // single-point box: center only, everything else out of range
        set_grid(11'd1, 11'd1, 11'd1, 24'd0, 24'd0, 24'd0);
        send_point(0, 0, 0);
        send_point(1, 0, 0);
        send_point(0, 0, 1);
        drain();

        // zero extent flags every point
        set_grid(11'd0, 11'd5, 11'd5, 24'd1, 24'd2, 24'd3);
        send_point(0, 0, 0);
        send_point(3, 2, 1);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            set_grid(pick_extent(), pick_extent(), pick_extent(),
                     COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
            random_points(30);
            drain();
        end

        // back-to-back points for the tail of the run
        allow_gaps = 1'b0;
        set_grid(EXT_W'($urandom_range(2, 9)), EXT_W'($urandom_range(2, 9)),
                 EXT_W'($urandom_range(2, 9)),
                 COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
        random_points(20);
        drain();
        repeat (20) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
